### sv/dlcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcg_pkg - shared types and constants for the dual LCG random source
// Item kinds, sequencer states, LCG constants and the seed interleave helper.
// ----------------------------------------------------------------------------
package dlcg_pkg;

  localparam int SEED_W  = 64;
  localparam int HALF_W  = 32;
  localparam int SPAN_W  = HALF_W + 1;
  localparam int CNT_W   = $clog2(SEED_W);
  localparam int IN_W    = 136;
  localparam int OUT_W   = 96;

  localparam logic [63:0] MUL_LO_FULL = 64'd131421833123;
  localparam logic [31:0] MUL_LO      = MUL_LO_FULL[31:0];
  localparam logic [31:0] ADD_LO      = 32'd1312379;
  localparam logic [31:0] MUL_HI      = 32'd232138911;
  localparam logic [31:0] ADD_HI      = 32'd7931307;
  localparam logic [4:0]  ABSORB_SHIFT = 5'd5;  // seed * 31 = (seed << 5) - seed

  typedef enum logic [1:0] {
    KIND_ABSORB = 2'd0,
    KIND_DRAW   = 2'd1,
    KIND_LOAD   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MIX,
    ST_DIV
  } state_t;

  // {a[31:16], b[31:16], a[15:0], b[15:0]} from bit 63 down
  function automatic logic [SEED_W-1:0] interleave(input logic [HALF_W-1:0] a,
                                                   input logic [HALF_W-1:0] b);
    return {a[31:16], b[31:16], a[15:0], b[15:0]};
  endfunction

endpackage

### sv/dual_lcg_seeded_range_random.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_lcg_seeded_range_random - seeded dual LCG source with ranged draws
// Absorb, load and in-range draw beats update a 64-bit seed; draws return
// the raw seed and a value reduced into [range_low, range_high] or range_error.
// ----------------------------------------------------------------------------
// Absorb, load, inverted-range draw and unused kinds: result in the cycle after
//   the beat is taken; one such beat per cycle while the output is drained.
// Draw: ST_MUL_LO and ST_MUL_HI (two passes through the shared 32x32 multiplier),
//   then ST_MIX and ST_DIV (a radix-2 restoring remainder unit, a bit per step);
//   input is not ready meanwhile, so no new beat is taken until the draw is done.
// Reset (synchronous, rst high) clears the seed to zero and empties the output.
module dual_lcg_seeded_range_random (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [7:0] data_byte, [71:8] seed_value, [103:72] range_low, [135:104] range_high
  input  logic [dlcg_pkg::IN_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [31:0] ranged_value, [95:32] raw_draw
  output logic [dlcg_pkg::OUT_W-1:0] m_axis_tdata,
  // [0] range_error
  output logic                      m_axis_tuser
);

  dlcg_pkg::state_t state, state_next;

  logic [dlcg_pkg::SEED_W-1:0] seed;
  logic [dlcg_pkg::SEED_W-1:0] dividend;
  logic [dlcg_pkg::SPAN_W-1:0] rem;
  logic [dlcg_pkg::SPAN_W-1:0] span;
  logic [dlcg_pkg::HALF_W-1:0] low_r;
  logic [dlcg_pkg::HALF_W-1:0] prod;
  logic [dlcg_pkg::HALF_W-1:0] lcg_a;
  logic [dlcg_pkg::CNT_W-1:0]  cnt;

  // input fields
  logic [7:0]                  in_byte;
  logic [dlcg_pkg::SEED_W-1:0] in_seed;
  logic [dlcg_pkg::HALF_W-1:0] in_low;
  logic [dlcg_pkg::HALF_W-1:0] in_high;
  logic                        accept;
  logic                        inverted;
  logic [dlcg_pkg::SPAN_W-1:0] span_in;

  // shared multiplier
  logic [dlcg_pkg::HALF_W-1:0] mul_x;
  logic [dlcg_pkg::HALF_W-1:0] mul_k;
  logic [dlcg_pkg::HALF_W-1:0] mul_p;

  logic [dlcg_pkg::HALF_W-1:0] lcg_b;
  logic [dlcg_pkg::SEED_W-1:0] mixed;
  logic [dlcg_pkg::SPAN_W:0]   trial;
  logic [dlcg_pkg::SPAN_W-1:0] rem_next;
  logic [dlcg_pkg::SEED_W-1:0] absorbed;

  assign in_byte = s_axis_tdata[7:0];
  assign in_seed = s_axis_tdata[71:8];
  assign in_low  = s_axis_tdata[103:72];
  assign in_high = s_axis_tdata[135:104];
  assign accept  = s_axis_tvalid && s_axis_tready;

  assign inverted = $signed(in_low) > $signed(in_high);
  assign span_in  = {in_high[31], in_high} - {in_low[31], in_low}
                    + {{(dlcg_pkg::SPAN_W-1){1'b0}}, 1'b1};

  assign absorbed = (seed << dlcg_pkg::ABSORB_SHIFT) - seed
                    + {{(dlcg_pkg::SEED_W-8){1'b0}}, in_byte};

  assign mul_p = 32'(mul_x * mul_k);
  assign lcg_b = prod + dlcg_pkg::ADD_HI;
  assign mixed = dlcg_pkg::interleave(lcg_a, lcg_b);

  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign trial    = {rem, dividend[dlcg_pkg::SEED_W-1]};
  assign rem_next = (trial >= {1'b0, span}) ? 33'(trial - {1'b0, span}) : trial[32:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dlcg_pkg::ST_IDLE: begin
        if (accept && s_axis_tuser == dlcg_pkg::KIND_DRAW && !inverted)
          state_next = dlcg_pkg::ST_MUL_LO;
      end
      dlcg_pkg::ST_MUL_LO: state_next = dlcg_pkg::ST_MUL_HI;
      dlcg_pkg::ST_MUL_HI: state_next = dlcg_pkg::ST_MIX;
      dlcg_pkg::ST_MIX:    state_next = dlcg_pkg::ST_DIV;
      dlcg_pkg::ST_DIV: begin
        if (cnt == dlcg_pkg::CNT_W'(dlcg_pkg::SEED_W - 1))
          state_next = dlcg_pkg::ST_IDLE;
      end
      default: state_next = dlcg_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mul_x = seed[31:0];
    mul_k = dlcg_pkg::MUL_LO;
    unique case (state)
      dlcg_pkg::ST_IDLE:   s_axis_tready = !m_axis_tvalid || m_axis_tready;
      dlcg_pkg::ST_MUL_LO: begin
        mul_x = seed[31:0];
        mul_k = dlcg_pkg::MUL_LO;
      end
      dlcg_pkg::ST_MUL_HI: begin
        mul_x = seed[63:32];
        mul_k = dlcg_pkg::MUL_HI;
      end
      dlcg_pkg::ST_MIX, dlcg_pkg::ST_DIV: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dlcg_pkg::ST_IDLE;
      seed          <= '0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready)
        m_axis_tvalid <= 1'b0;

      unique case (state)
        dlcg_pkg::ST_IDLE: begin
          if (accept) begin
            low_r <= in_low;
            span  <= span_in;
            case (s_axis_tuser)
              dlcg_pkg::KIND_ABSORB: begin
                seed          <= absorbed;
                m_axis_tvalid <= 1'b1;
                m_axis_tdata  <= {absorbed, {dlcg_pkg::HALF_W{1'b0}}};
                m_axis_tuser  <= 1'b0;
              end
              dlcg_pkg::KIND_LOAD: begin
                seed          <= in_seed;
                m_axis_tvalid <= 1'b1;
                m_axis_tdata  <= {in_seed, {dlcg_pkg::HALF_W{1'b0}}};
                m_axis_tuser  <= 1'b0;
              end
              dlcg_pkg::KIND_DRAW: begin
                // inverted range: report and hold the seed; else start the draw
                if (inverted) begin
                  m_axis_tvalid <= 1'b1;
                  m_axis_tdata  <= {seed, {dlcg_pkg::HALF_W{1'b0}}};
                  m_axis_tuser  <= 1'b1;
                end
              end
              default: begin
                m_axis_tvalid <= 1'b1;
                m_axis_tdata  <= {seed, {dlcg_pkg::HALF_W{1'b0}}};
                m_axis_tuser  <= 1'b0;
              end
            endcase
          end
        end
        dlcg_pkg::ST_MUL_LO: prod <= mul_p;
        dlcg_pkg::ST_MUL_HI: begin
          lcg_a <= prod + dlcg_pkg::ADD_LO;
          prod  <= mul_p;
        end
        dlcg_pkg::ST_MIX: begin
          seed     <= mixed;
          dividend <= mixed;
          rem      <= '0;
          cnt      <= '0;
        end
        dlcg_pkg::ST_DIV: begin
          rem      <= rem_next;
          dividend <= dividend << 1;
          cnt      <= cnt + 1'b1;
          if (cnt == dlcg_pkg::CNT_W'(dlcg_pkg::SEED_W - 1)) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {seed, low_r + rem_next[31:0]};
            m_axis_tuser  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // a valid draw leaves the output empty while the sequencer works
  assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tuser == dlcg_pkg::KIND_DRAW && !inverted) |=> !m_axis_tvalid)
    else $error("output busy during draw");

  // partial remainder stays below the modulus
  assert property (@(posedge clk) disable iff (rst)
    (state == dlcg_pkg::ST_DIV) |-> (rem < span))
    else $error("remainder out of range");

  // the bit counter only runs inside the remainder loop
  assert property (@(posedge clk) disable iff (rst)
    (state != dlcg_pkg::ST_DIV) |-> (cnt == '0))
    else $error("stray remainder count");

  // a pending result always shows the current seed
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[95:32] == seed))
    else $error("raw value differs from seed");

endmodule
